@@ hdl/tbgd_pkg.sv @@
// Types and constants shared by the two-button gesture detector.
// Holds the mode and event encodings and the register index codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbgd_pkg;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_FIELD_W = 16;
    localparam int unsigned NOW_W       = 32;
    localparam int unsigned EVENT_W     = 3;

    localparam logic [CFG_FIELD_W-1:0] HOLD_THRESHOLD_RESET  = 16'd500;
    localparam logic [CFG_FIELD_W-1:0] REPEAT_INTERVAL_RESET = 16'd0;

    typedef enum logic {
        REG_HOLD_THRESHOLD  = 1'b0,
        REG_REPEAT_INTERVAL = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_A    = 3'd1,
        MODE_B    = 3'd2,
        MODE_BOTH = 3'd3,
        MODE_WAIT = 3'd4
    } t_mode;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE       = 3'd0,
        EV_A_TAP      = 3'd1,
        EV_A_HOLD     = 3'd2,
        EV_B_TAP      = 3'd3,
        EV_B_HOLD     = 3'd4,
        EV_CHORD_TAP  = 3'd5,
        EV_CHORD_HOLD = 3'd6
    } t_event;

endpackage

`default_nettype wire

@@ hdl/tbgd_if.sv @@
// Valid/ready channel interfaces of the two-button gesture detector.
// tbgd_in_if carries button samples, tbgd_out_if carries event codes.
// Depends on tbgd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tbgd_in_if
    import tbgd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             button_a_down;
    logic             button_b_down;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, output button_a_down, output button_b_down,
                    output now_ms, input ready);
    modport sink   (input valid, input button_a_down, input button_b_down,
                    input now_ms, output ready);
endinterface

interface tbgd_out_if
    import tbgd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

`default_nettype wire

@@ hdl/two_button_gesture_detector_core.sv @@
// Two-button gesture detector core: sample register, gesture state machine,
// event result register and APB-style configuration registers.
// Depends on tbgd_pkg and the channel interfaces in tbgd_if.sv.
//
// Usage:
//   i_in carries one sample per transaction: both button levels and a
//   free-running millisecond timestamp. o_out carries exactly one event
//   code per sample, in sample order (0 means no gesture).
//   An input transaction passes through the sample register and then the
//   event register before it shows on o_out.valid.
//   Throughput is one sample per cycle while o_out.ready stays high; the
//   gesture state is updated when a sample moves into the event register.
//   When the receiver stalls, the event register holds its transaction and
//   the sample register still takes one more sample; i_in.ready then drops
//   until o_out.ready returns.
//   Reset (i_rst_n low, synchronous) empties both registers, puts the
//   machine in idle, clears the press times and the hold flag, and sets
//   hold_threshold_ms to 500 and repeat_interval_ms to 0.
//   Configuration: register 0 (hold_threshold_ms) at byte address 0,
//   register 1 (repeat_interval_ms) at byte address 4; write only while
//   no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none

module two_button_gesture_detector_core
    import tbgd_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    tbgd_in_if.sink               i_in,
    tbgd_out_if.source            o_out,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [CFG_ADDR_W-1:0] paddr,
    input  wire  [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef logic [TIME_BITS-1:0] t_time;

    logic [CFG_FIELD_W-1:0] r_hold_threshold;
    logic [CFG_FIELD_W-1:0] r_repeat_interval;

    logic             r_s1_valid;
    logic             r_s1_a;
    logic             r_s1_b;
    logic [NOW_W-1:0] r_s1_now;

    logic   r_out_valid;
    t_event r_out_event;

    t_mode  r_mode;
    t_time  r_press_start;
    t_time  r_last_repeat;
    logic   r_hold_reported;

    t_mode  n_mode;
    t_time  n_press_start;
    t_time  n_last_repeat;
    logic   n_hold_reported;
    t_event n_event;

    logic   s1_advance;
    logic   s1_process;
    logic   cfg_write;
    t_time  now_t;
    t_time  since_start;
    t_time  since_repeat;
    logic   hold_due;
    logic   repeat_due;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_threshold  <= HOLD_THRESHOLD_RESET;
            r_repeat_interval <= REPEAT_INTERVAL_RESET;
        end else if (cfg_write) begin
            case (t_reg_index'(paddr[2])) 
                REG_HOLD_THRESHOLD:  r_hold_threshold  <= pwdata[CFG_FIELD_W-1:0];
                REG_REPEAT_INTERVAL: r_repeat_interval <= pwdata[CFG_FIELD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_index'(paddr[2]))
            REG_HOLD_THRESHOLD:  prdata = CFG_DATA_W'(r_hold_threshold);
            REG_REPEAT_INTERVAL: prdata = CFG_DATA_W'(r_repeat_interval);
            default:             prdata = '0;
        endcase
    end

    // handshake
    assign s1_advance  = !r_out_valid || o_out.ready;
    assign s1_process  = r_s1_valid && s1_advance;
    assign i_in.ready  = !r_s1_valid || s1_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_a   <= i_in.button_a_down;
            r_s1_b   <= i_in.button_b_down;
            r_s1_now <= i_in.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_process) begin
            r_out_event <= n_event;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_code = r_out_event;

    // gesture state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_IDLE;
            r_press_start   <= '0;
            r_last_repeat   <= '0;
            r_hold_reported <= 1'b0;
        end else if (s1_process) begin
            r_mode          <= n_mode;
            r_press_start   <= n_press_start;
            r_last_repeat   <= n_last_repeat;
            r_hold_reported <= n_hold_reported;
        end
    end

    assign now_t        = TIME_BITS'(r_s1_now);
    assign since_start  = now_t - r_press_start;
    assign since_repeat = now_t - r_last_repeat;
    assign hold_due     = since_start >= TIME_BITS'(r_hold_threshold);
    assign repeat_due   = (r_repeat_interval != '0)
                          && (since_repeat >= TIME_BITS'(r_repeat_interval));

    always_comb begin
        n_mode          = r_mode;
        n_press_start   = r_press_start;
        n_last_repeat   = r_last_repeat;
        n_hold_reported = r_hold_reported;
        n_event         = EV_NONE;
        case (r_mode)
            MODE_IDLE: begin
                if (r_s1_a || r_s1_b) begin
                    n_mode          = (r_s1_a && r_s1_b) ? MODE_BOTH
                                      : (r_s1_a ? MODE_A : MODE_B);
                    n_press_start   = now_t;
                    n_last_repeat   = now_t;
                    n_hold_reported = 1'b0;
                end
            end
            MODE_A, MODE_B: begin
                if (r_s1_a && r_s1_b) begin
                    n_mode          = MODE_BOTH;
                    n_press_start   = now_t;
                    n_last_repeat   = now_t;
                    n_hold_reported = 1'b0;
                end else if ((r_mode == MODE_A) ? !r_s1_a : !r_s1_b) begin
                    n_mode = MODE_IDLE;
                    if (!r_hold_reported) begin
                        if (r_mode == MODE_A) begin
                            n_event = hold_due ? EV_A_HOLD : EV_A_TAP;
                        end else begin
                            n_event = hold_due ? EV_B_HOLD : EV_B_TAP;
                        end
                    end
                end else if (!r_hold_reported ? hold_due : repeat_due) begin
                    n_hold_reported = 1'b1;
                    n_last_repeat   = now_t;
                    n_event         = (r_mode == MODE_A) ? EV_A_HOLD : EV_B_HOLD;
                end
            end
            MODE_BOTH: begin
                if (!r_s1_a || !r_s1_b) begin
                    n_mode  = (!r_s1_a && !r_s1_b) ? MODE_IDLE : MODE_WAIT;
                    n_event = r_hold_reported ? EV_NONE : EV_CHORD_TAP;
                end else if (!r_hold_reported && hold_due) begin
                    n_hold_reported = 1'b1;
                    n_event         = EV_CHORD_HOLD;
                end
            end
            default: begin
                if (!r_s1_a && !r_s1_b) begin
                    n_mode = MODE_IDLE;
                end
            end
        endcase
    end

    a_ready_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready
    ) else $error("input not ready while event register is empty");

    a_out_from_sample: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_process)
    ) else $error("event appeared without a processed sample");

    a_press_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_process && r_mode == MODE_IDLE && (r_s1_a || r_s1_b))
        |=> (!r_hold_reported && r_press_start == r_last_repeat)
    ) else $error("press start did not reset hold tracking");

    a_wait_silent: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_process && r_mode == MODE_WAIT) |=> (r_out_event == EV_NONE)
    ) else $error("event emitted while waiting for release");

    a_chord_hold_once: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_process && r_mode == MODE_BOTH && r_hold_reported)
        |=> (r_out_event != EV_CHORD_HOLD)
    ) else $error("chord hold reported twice");

endmodule

`default_nettype wire
